// File: hw/rtl/tlcq_pkg.sv
// shared types and constants for the three-level circular queue block
package tlcq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 4;
  localparam int DEFAULT_NUM_QUEUES  = 3;
  localparam int DATA_W              = 32;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic load_out;
  } tlcq_cmd_t;

endpackage

// File: hw/rtl/tlcq_ram.sv
// generic single-write, single-read ram with registered read data
module tlcq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/tlcq_ctrl.sv
// controller state machine sequencing one queue operation at a time
module tlcq_ctrl
  import tlcq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tlcq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_LOAD
  } state_t;

  state_t state;

  assign in_ready     = (state == S_IDLE);
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.execute  = (state == S_PICK);
  // result register may only be refilled once the old result has left
  assign cmd.load_out = (state == S_LOAD) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register loaded while a result is still waiting");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> cmd.execute)
    else $error("accepted item not executed in the next cycle");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.execute, cmd.load_out}))
    else $error("more than one datapath command at once");

endmodule

// File: hw/rtl/tlcq_datapath.sv
// queue pointers, fill counts, slot storage and result registers
module tlcq_datapath
  import tlcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  parameter int NUM_QUEUES  = DEFAULT_NUM_QUEUES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tlcq_cmd_t                cmd,
  input  logic                     mode,
  input  logic signed [DATA_W-1:0] data_value,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] popped_value,
  output logic [1:0]               queue_used
);

  localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic              item_mode;
  logic [DATA_W-1:0] item_value;

  logic [PTR_W-1:0] head [NUM_QUEUES];
  logic [PTR_W-1:0] tail [NUM_QUEUES];
  logic [CNT_W-1:0] fill [NUM_QUEUES];

  logic              found;
  logic [QIDX_W-1:0] sel;
  logic [PTR_W-1:0]  slot_ptr;
  logic [ADDR_W-1:0] slot_addr;
  logic              wr_en;
  logic              rd_en;
  logic [DATA_W-1:0] rd_data;

  status_t           res_status;
  logic [QIDX_W-1:0] res_queue;
  logic              res_pop;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode  <= mode;
      item_value <= data_value;
    end
  end

  // lowest-numbered queue with room (insert) or with data (delete) wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
      if (item_mode ? (fill[q] != '0) : (fill[q] != CNT_W'(QUEUE_DEPTH))) begin
        found = 1'b1;
        sel   = QIDX_W'(q);
      end
    end
  end

  assign slot_ptr  = item_mode ? head[sel] : tail[sel];
  assign slot_addr = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot_ptr);
  assign wr_en     = cmd.execute && found && !item_mode;
  assign rd_en     = cmd.execute && found && item_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head[q] <= '0;
        tail[q] <= '0;
        fill[q] <= '0;
      end
    end else if (cmd.execute && found) begin
      if (item_mode) begin
        head[sel] <= wrap_inc(head[sel]);
        fill[sel] <= fill[sel] - CNT_W'(1);
      end else begin
        tail[sel] <= wrap_inc(tail[sel]);
        fill[sel] <= fill[sel] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_pop   <= item_mode;
      res_queue <= found ? sel : '0;
      if (found) begin
        res_status <= ST_DONE;
      end else if (item_mode) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_FULL;
      end
    end
  end

  tlcq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(slot_addr),
    .wr_data(item_value),
    .rd_en  (rd_en),
    .rd_addr(slot_addr),
    .rd_data(rd_data)
  );

  // read data arrives the cycle after execute, in time for the load
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= res_status;
      queue_used   <= 2'(res_queue);
      popped_value <= (res_pop && res_status == ST_DONE) ? rd_data : '0;
    end
  end

  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_chk
    a_fill_bound: assert property (@(posedge clk) disable iff (rst)
      fill[g] <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count above depth");
  end

endmodule

// File: hw/rtl/three_level_circular_queues.sv
// Fixed-priority set of NUM_QUEUES circular FIFOs of signed 32-bit words, each
// QUEUE_DEPTH deep. An insert (mode 0) goes to the lowest-numbered queue with
// room, a delete (mode 1) pops the oldest word of the lowest-numbered non-empty
// queue; each transfer in yields one result with status, popped value and queue
// index. Each item passes the pick state (pick, pointer update and registered
// slot ram read) and then the load state (result load into the output
// register); the next item is taken the cycle after the result is loaded, so
// a new item is not accepted until the last result has been loaded; a result
// still waiting holds off the load and so the input. Slot storage is not
// cleared at reset; only pointers and fill counts are.
module three_level_circular_queues
  import tlcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  parameter int NUM_QUEUES  = DEFAULT_NUM_QUEUES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     mode,
  input  logic signed [DATA_W-1:0] data_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] popped_value,
  output logic [1:0]               queue_used
);

  tlcq_cmd_t cmd;

  tlcq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  tlcq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .data_value  (data_value),
    .status      (status),
    .popped_value(popped_value),
    .queue_used  (queue_used)
  );

endmodule
